### rtl/rtec_pkg.sv
// ----------------------------------------------------------------------------
// rtec_pkg
// Types and constants shared by the reduced temperature correlation pipeline.
// ----------------------------------------------------------------------------
package rtec_pkg;

  typedef struct packed {
    logic vld;
    logic sat;
    logic ovf;
  } rtec_ctl_t;

  typedef enum logic [2:0] {
    CFG_COEF_CBRT        = 3'd0,
    CFG_COEF_FOUR_THIRDS = 3'd1,
    CFG_CRITICAL_TEMP    = 3'd2,
    CFG_OFFSET_TEMP      = 3'd3,
    CFG_SCALE_FACTOR     = 3'd4
  } rtec_cfg_idx_t;

  localparam int DIV_STAGES  = 33;
  localparam int CBRT_STAGES = 23;
  localparam int EXP_STAGES  = 31;
  localparam int TOP_STAGES  = 10;

endpackage

### rtl/reduced_temp_exp_correlation_unit.sv
// ----------------------------------------------------------------------------
// reduced_temp_exp_correlation_unit
// Evaluates scale * exp(a * Tr^(1/3) + b * Tr^(4/3)) on the reduced
// temperature Tr = (critical - T) / (T - offset), in fixed point.
//
// Usage:
//   - a temperature word is taken at each clock edge with start high; busy
//     stays low, so a new word may follow every cycle
//   - each result is shown on out_property_value / out_saturated for one
//     cycle with out_valid high
//   - throughput is one word per cycle; each word passes the 32-step
//     divider, the 22-step cube root and the 13-term series of the exp unit
//   - the receiver cannot stall; results are never held back
//   - five coefficient registers are written through cfg_valid / cfg_index /
//     cfg_data; the user must write them only while no word is in flight (not
//     enforced); cfg_ready is always high; an index beyond the list is dropped
//   - synchronous reset clears the registers to zero and empties the
//     pipeline; words in flight are lost
// ----------------------------------------------------------------------------
module reduced_temp_exp_correlation_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_temperature,
  output logic        out_valid,
  output logic [62:0] out_property_value,
  output logic        out_saturated,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import rtec_pkg::*;

  localparam int LAT = DIV_STAGES + CBRT_STAGES + EXP_STAGES + TOP_STAGES;

  // coefficient registers
  logic [31:0] coef_cbrt_term_r, coef_four_thirds_term_r;
  logic [31:0] critical_temp_r, offset_temp_r;
  logic [63:0] scale_factor_r;
  logic [31:0] mag_a_r, mag_b_r;
  logic        neg_a_r, neg_b_r, scale_pos_r;

  // front end
  logic        v0_r, v1_r;
  logic [31:0] t_r, num_r, den_r;
  logic [31:0] tlim;

  rtec_ctl_t   div_ctl, cb_ctl, exp_ctl;
  logic [31:0] div_tr, cb_tr;
  logic [21:0] cb_cb;
  logic [63:0] exp_e;

  // term stages
  rtec_ctl_t          p1_ctl_r, p2_ctl_r, p3_ctl_r, p4_ctl_r;
  logic [37:0]        f43_r;
  logic [21:0]        cb1_r;
  logic [37:0]        pah_r;
  logic [47:0]        pal_r, pbl_r;
  logic [53:0]        pbh_r, pb_r;
  logic [37:0]        pa_r;
  logic signed [55:0] arg_r;
  logic [55:0]        sa, sb;

  // scale product stages
  rtec_ctl_t    m1_ctl_r, m2_ctl_r, m3_ctl_r;
  logic [63:0]  p00_r, p01_r, p10_r, p11_r, p00b_r, p11b_r;
  logic [64:0]  mid_r;
  logic [127:0] full_r;

  logic        out_valid_r, out_saturated_r;
  logic [62:0] out_property_value_r;
  logic [62:0] val_nxt;
  logic        sat_nxt;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_cbrt_term_r        <= '0;
      coef_four_thirds_term_r <= '0;
      critical_temp_r         <= '0;
      offset_temp_r           <= '0;
      scale_factor_r          <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_COEF_CBRT:        coef_cbrt_term_r        <= cfg_data[31:0];
        CFG_COEF_FOUR_THIRDS: coef_four_thirds_term_r <= cfg_data[31:0];
        CFG_CRITICAL_TEMP:    critical_temp_r         <= cfg_data[31:0];
        CFG_OFFSET_TEMP:      offset_temp_r           <= cfg_data[31:0];
        CFG_SCALE_FACTOR:     scale_factor_r          <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    neg_a_r     <= coef_cbrt_term_r[31];
    neg_b_r     <= coef_four_thirds_term_r[31];
    mag_a_r     <= coef_cbrt_term_r[31] ? ~coef_cbrt_term_r + 32'd1 : coef_cbrt_term_r;
    mag_b_r     <= coef_four_thirds_term_r[31] ? ~coef_four_thirds_term_r + 32'd1
                                               : coef_four_thirds_term_r;
    scale_pos_r <= !scale_factor_r[63] && (scale_factor_r != '0);
  end

  // clamp and reduced variable operands
  assign tlim = (t_r < critical_temp_r) ? t_r : critical_temp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= start && !busy;
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    t_r   <= in_temperature;
    num_r <= critical_temp_r - tlim;
    den_r <= (tlim > offset_temp_r) ? tlim - offset_temp_r : 32'd1;
  end

  rtec_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (v1_r),
    .in_num  (num_r),
    .in_den  (den_r),
    .out_ctl (div_ctl),
    .out_tr  (div_tr)
  );

  rtec_cbrt u_cbrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ctl  (div_ctl),
    .in_tr   (div_tr),
    .out_ctl (cb_ctl),
    .out_tr  (cb_tr),
    .out_cb  (cb_cb)
  );

  // exponent argument: a * cbrt + b * four-thirds power
  assign sa = neg_a_r ? ~{18'h0, pa_r} + 56'd1 : {18'h0, pa_r};
  assign sb = neg_b_r ? ~{2'b00, pb_r} + 56'd1 : {2'b00, pb_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_ctl_r <= '0;
      p2_ctl_r <= '0;
      p3_ctl_r <= '0;
      p4_ctl_r <= '0;
    end else begin
      p1_ctl_r <= cb_ctl;
      p2_ctl_r <= p1_ctl_r;
      p3_ctl_r <= p2_ctl_r;
      p4_ctl_r <= p3_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    f43_r <= 38'((54'(cb_tr) * 54'(cb_cb)) >> 16);
    cb1_r <= cb_cb;
    pah_r <= 38'(mag_a_r) * 38'(cb1_r[21:16]);
    pal_r <= 48'(mag_a_r) * 48'(cb1_r[15:0]);
    pbh_r <= 54'(mag_b_r) * 54'(f43_r[37:16]);
    pbl_r <= 48'(mag_b_r) * 48'(f43_r[15:0]);
    pa_r  <= pah_r + 38'(pal_r[47:16]);
    pb_r  <= pbh_r + 54'(pbl_r[47:16]);
    arg_r <= $signed(sa + sb);
  end

  rtec_exp u_exp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ctl  (p4_ctl_r),
    .in_arg  (arg_r),
    .out_ctl (exp_ctl),
    .out_e   (exp_e)
  );

  // scale * exp as four partial products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_ctl_r    <= '0;
      m2_ctl_r    <= '0;
      m3_ctl_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      m1_ctl_r    <= exp_ctl;
      m2_ctl_r    <= m1_ctl_r;
      m3_ctl_r    <= m2_ctl_r;
      out_valid_r <= m3_ctl_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    p00_r  <= 64'(scale_factor_r[31:0])  * 64'(exp_e[31:0]);
    p01_r  <= 64'(scale_factor_r[31:0])  * 64'(exp_e[63:32]);
    p10_r  <= 64'(scale_factor_r[63:32]) * 64'(exp_e[31:0]);
    p11_r  <= 64'(scale_factor_r[63:32]) * 64'(exp_e[63:32]);
    mid_r  <= 65'(p01_r) + 65'(p10_r);
    p00b_r <= p00_r;
    p11b_r <= p11_r;
    full_r <= {p11b_r, p00b_r} + {31'h0, mid_r, 32'h0};
  end

  always_comb begin
    if (m3_ctl_r.ovf) begin
      val_nxt = scale_pos_r ? '1 : '0;
      sat_nxt = 1'b1;
    end else if (!scale_pos_r) begin
      val_nxt = '0;
      sat_nxt = m3_ctl_r.sat;
    end else if (full_r[127:95] != '0) begin
      val_nxt = '1;
      sat_nxt = 1'b1;
    end else begin
      val_nxt = full_r[94:32];
      sat_nxt = m3_ctl_r.sat;
    end
  end

  always_ff @(posedge clk) begin
    out_property_value_r <= val_nxt;
    out_saturated_r      <= sat_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_property_value = out_property_value_r;
  assign out_saturated      = out_saturated_r;

  a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LAT out_valid)
    else $error("word accepted without a result after the pipeline latency");

  a_latency_bwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result strobe without a matching accepted word");

  a_exp_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (exp_ctl.vld && exp_ctl.ovf) |-> (exp_e == '0))
    else $error("exponential overflow with a non-zero value");

endmodule

### rtl/rtec_div.sv
// ----------------------------------------------------------------------------
// rtec_div
// Pipelined restoring divider, one quotient bit per stage: (num << 16) / den,
// saturating to all ones when the quotient needs more than 32 bits.
// ----------------------------------------------------------------------------
module rtec_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  logic [31:0]         in_num,
  input  logic [31:0]         in_den,
  output rtec_pkg::rtec_ctl_t out_ctl,
  output logic [31:0]         out_tr
);
  import rtec_pkg::*;

  localparam int N = DIV_STAGES - 1;

  logic        vld_r [0:N];
  logic        sat_r [0:N];
  logic [31:0] rem_r [0:N];
  logic [31:0] dvd_r [0:N];
  logic [31:0] quo_r [0:N];
  logic [31:0] den_r [0:N];

  logic [32:0] trial   [1:N];
  logic        ge      [1:N];
  logic [31:0] rem_nxt [1:N];

  always_comb begin
    for (int i = 1; i <= N; i++) begin
      trial[i]   = {rem_r[i-1], dvd_r[i-1][31]};
      ge[i]      = trial[i] >= {1'b0, den_r[i-1]};
      rem_nxt[i] = ge[i] ? 32'(trial[i] - {1'b0, den_r[i-1]}) : trial[i][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= N; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
      for (int i = 1; i <= N; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    // quotient overflows 32 bits when num >= den * 2^16
    sat_r[0] <= {16'h0, in_num} >= {in_den, 16'h0};
    rem_r[0] <= {16'h0, in_num[31:16]};
    dvd_r[0] <= {in_num[15:0], 16'h0};
    quo_r[0] <= '0;
    den_r[0] <= in_den;
    for (int i = 1; i <= N; i++) begin
      sat_r[i] <= sat_r[i-1];
      rem_r[i] <= rem_nxt[i];
      dvd_r[i] <= {dvd_r[i-1][30:0], 1'b0};
      quo_r[i] <= {quo_r[i-1][30:0], ge[i]};
      den_r[i] <= den_r[i-1];
    end
  end

  assign out_ctl = '{vld: vld_r[N], sat: sat_r[N], ovf: 1'b0};
  assign out_tr  = sat_r[N] ? 32'hFFFF_FFFF : quo_r[N];

endmodule

### rtl/rtec_cbrt.sv
// ----------------------------------------------------------------------------
// rtec_cbrt
// Pipelined digit-by-digit integer cube root of tr << 32, one result bit per
// stage, with the square of the partial root kept incrementally.
// ----------------------------------------------------------------------------
module rtec_cbrt (
  input  logic                clk,
  input  logic                rst_n,
  input  rtec_pkg::rtec_ctl_t in_ctl,
  input  logic [31:0]         in_tr,
  output rtec_pkg::rtec_ctl_t out_ctl,
  output logic [31:0]         out_tr,
  output logic [21:0]         out_cb
);
  import rtec_pkg::*;

  localparam int N = CBRT_STAGES - 1;

  rtec_ctl_t   ctl_r [0:N];
  logic [63:0] x_r   [0:N];
  logic [21:0] y_r   [0:N];
  logic [43:0] y2_r  [0:N];
  logic [31:0] tr_r  [0:N];

  logic [21:0] yd     [1:N];
  logic [43:0] y2d    [1:N];
  logic [44:0] bs     [1:N];
  logic [45:0] bv     [1:N];
  logic [63:0] xs     [1:N];
  logic        ge     [1:N];
  logic [63:0] x_nxt  [1:N];
  logic [21:0] y_nxt  [1:N];
  logic [43:0] y2_nxt [1:N];

  always_comb begin
    for (int i = 1; i <= N; i++) begin
      yd[i]  = {y_r[i-1][20:0], 1'b0};
      y2d[i] = {y2_r[i-1][41:0], 2'b00};
      // b = 3 * y * (y + 1) + 1
      bs[i]  = {1'b0, y2d[i]} + {23'h0, yd[i]};
      bv[i]  = {bs[i], 1'b0} + {1'b0, bs[i]} + 46'd1;
      xs[i]  = x_r[i-1] >> (63 - 3 * (i - 1));
      ge[i]  = xs[i] >= {18'h0, bv[i]};
      x_nxt[i]  = ge[i] ? x_r[i-1] - ({18'h0, bv[i]} << (63 - 3 * (i - 1))) : x_r[i-1];
      y_nxt[i]  = ge[i] ? yd[i] + 22'd1 : yd[i];
      y2_nxt[i] = ge[i] ? y2d[i] + {21'h0, yd[i], 1'b0} + 44'd1 : y2d[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= N; i++) ctl_r[i] <= '0;
    end else begin
      ctl_r[0] <= in_ctl;
      for (int i = 1; i <= N; i++) ctl_r[i] <= ctl_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    x_r[0]  <= {in_tr, 32'h0};
    y_r[0]  <= '0;
    y2_r[0] <= '0;
    tr_r[0] <= in_tr;
    for (int i = 1; i <= N; i++) begin
      x_r[i]  <= x_nxt[i];
      y_r[i]  <= y_nxt[i];
      y2_r[i] <= y2_nxt[i];
      tr_r[i] <= tr_r[i-1];
    end
  end

  assign out_ctl = ctl_r[N];
  assign out_tr  = tr_r[N];
  assign out_cb  = y_r[N];

endmodule

### rtl/rtec_exp.sv
// ----------------------------------------------------------------------------
// rtec_exp
// Pipelined Q16.16 to Q32.32 exponential: range split through log2 e, a
// thirteen-term Taylor series of e^r, two stages per term, then a scale by 2^n.
// ----------------------------------------------------------------------------
module rtec_exp (
  input  logic                clk,
  input  logic                rst_n,
  input  rtec_pkg::rtec_ctl_t in_ctl,
  input  logic signed [55:0]  in_arg,
  output rtec_pkg::rtec_ctl_t out_ctl,
  output logic [63:0]         out_e
);
  import rtec_pkg::*;

  localparam logic signed [55:0] EXP_LIM = 56'sd2097152;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam int TS = 3;
  localparam int TE = EXP_STAGES - 2;

  function automatic logic [32:0] recip_m(input int k);
    logic [32:0] m;
    case (k)
      3:       m = 33'd5726623062;
      5:       m = 33'd6871947674;
      6:       m = 33'd5726623062;
      7:       m = 33'd4908534053;
      9:       m = 33'd7635497416;
      10:      m = 33'd6871947674;
      11:      m = 33'd6247225158;
      12:      m = 33'd5726623062;
      13:      m = 33'd5286113596;
      default: m = 33'h1_0000_0000;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] recip_s(input int k);
    logic [5:0] s;
    case (k) inside
      1:       s = 6'd32;
      2:       s = 6'd33;
      [3:4]:   s = 6'd34;
      [5:8]:   s = 6'd35;
      default: s = 6'd36;
    endcase
    return s;
  endfunction

  rtec_ctl_t          ctl0_r, ctl1_r, ctl2_r, ctl_e_r;
  logic               zr0_r, zr1_r, zr2_r;
  logic               neg0_r, neg1_r;
  logic [20:0]        mag0_r;
  logic [51:0]        m1_r;
  logic signed [7:0]  n2_r;
  logic [45:0]        f2_r;
  logic [63:0]        e_r;

  rtec_ctl_t          ctl_r [TS:TE];
  logic               zr_r  [TS:TE];
  logic signed [7:0]  n_r   [TS:TE];
  logic [29:0]        rr_r  [TS:TE];
  logic [32:0]        tm_r  [TS:TE];
  logic [33:0]        sm_r  [TS:TE];

  logic [62:0] mp     [TS+1:TE];
  logic [64:0] dq     [TS+1:TE];
  logic [32:0] tm_nxt [TS+1:TE];
  logic [33:0] sm_nxt [TS+1:TE];

  logic [5:0]        q2;
  logic [45:0]       rm2;
  logic signed [7:0] n2_nxt;
  logic [45:0]       f2_nxt;
  logic [59:0]       rp3;
  logic              big_n;
  logic [5:0]        nsh;
  logic [63:0]       e_nxt;

  always_comb begin
    q2  = m1_r[51:46];
    rm2 = m1_r[45:0];
    if (!neg1_r) begin
      n2_nxt = {2'b00, q2};
      f2_nxt = rm2;
    end else if (rm2 == '0) begin
      n2_nxt = -$signed({2'b00, q2});
      f2_nxt = '0;
    end else begin
      n2_nxt = -$signed({2'b00, q2}) - 8'sd1;
      f2_nxt = ~rm2 + 46'd1;
    end
    rp3 = 60'(f2_r[45:16]) * 60'(LN2_Q30);
  end

  always_comb begin
    int j;
    int k;
    for (int s = TS + 1; s <= TE; s++) begin
      j = s - TS;
      k = (j + 1) >> 1;
      mp[s] = 63'(tm_r[s-1]) * 63'(rr_r[s-1]);
      dq[s] = (65'(tm_r[s-1][31:0]) * 65'(recip_m(k))) >> recip_s(k);
      if ((j & 1) == 1) begin
        tm_nxt[s] = {1'b0, mp[s][61:30]};
        sm_nxt[s] = sm_r[s-1];
      end else begin
        tm_nxt[s] = {1'b0, dq[s][31:0]};
        sm_nxt[s] = sm_r[s-1] + {2'b00, dq[s][31:0]};
      end
    end
  end

  always_comb begin
    big_n = n_r[TE] >= 8'sd31;
    nsh   = 6'(-n_r[TE]);
    if (zr_r[TE] || ctl_r[TE].ovf || big_n) begin
      e_nxt = '0;
    end else if (n_r[TE] >= 8'sd0) begin
      e_nxt = 64'(sm_r[TE]) << n_r[TE][4:0];
    end else if (n_r[TE] <= -8'sd40) begin
      e_nxt = '0;
    end else begin
      e_nxt = 64'(sm_r[TE]) >> nsh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r  <= '0;
      ctl1_r  <= '0;
      ctl2_r  <= '0;
      ctl_e_r <= '0;
      for (int s = TS; s <= TE; s++) ctl_r[s] <= '0;
    end else begin
      ctl0_r     <= '{vld: in_ctl.vld, sat: in_ctl.sat, ovf: in_arg >= EXP_LIM};
      ctl1_r     <= ctl0_r;
      ctl2_r     <= ctl1_r;
      ctl_r[TS]  <= ctl2_r;
      for (int s = TS + 1; s <= TE; s++) ctl_r[s] <= ctl_r[s-1];
      ctl_e_r    <= '{vld: ctl_r[TE].vld, sat: ctl_r[TE].sat,
                      ovf: ctl_r[TE].ovf | (!zr_r[TE] & big_n)};
    end
  end

  always_ff @(posedge clk) begin
    zr0_r  <= in_arg <= -EXP_LIM;
    neg0_r <= in_arg[55];
    mag0_r <= in_arg[55] ? 21'(-in_arg) : in_arg[20:0];
    m1_r   <= 52'(mag0_r) * 52'(LOG2E_Q30);
    zr1_r  <= zr0_r;
    neg1_r <= neg0_r;
    n2_r   <= n2_nxt;
    f2_r   <= f2_nxt;
    zr2_r  <= zr1_r;
    zr_r[TS] <= zr2_r;
    n_r[TS]  <= n2_r;
    rr_r[TS] <= rp3[59:30];
    tm_r[TS] <= 33'h1_0000_0000;
    sm_r[TS] <= 34'h1_0000_0000;
    for (int s = TS + 1; s <= TE; s++) begin
      zr_r[s] <= zr_r[s-1];
      n_r[s]  <= n_r[s-1];
      rr_r[s] <= rr_r[s-1];
      tm_r[s] <= tm_nxt[s];
      sm_r[s] <= sm_nxt[s];
    end
    e_r <= e_nxt;
  end

  assign out_ctl = ctl_e_r;
  assign out_e   = e_r;

endmodule
